@@ sv/ptw_pkg.sv @@
// Shared types and constants for the page table map walker.
package ptw_pkg;

  localparam int unsigned VA_W       = 48;
  localparam int unsigned PA_W       = 48;
  localparam int unsigned BASE_W     = 37;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned TABLE_ENTRIES = 512;
  localparam int unsigned PG_OFF_W   = 25;   // table address bits 36..12
  localparam int unsigned VPN_W      = 36;   // virtual address bits 47..12
  localparam int unsigned PPN_W      = 36;   // physical address bits 47..12
  localparam int unsigned DESC_W     = 48;
  localparam int unsigned OUT_PAGE_W = 6;
  localparam int unsigned NEW_W      = 2;
  localparam int unsigned LVL_W      = 2;
  localparam int unsigned S_TDATA_W  = 96;
  localparam int unsigned M_TDATA_W  = 64;

  localparam logic [11:0] DESC_ATTR  = 12'h743;

  localparam logic [LVL_W-1:0] LVL_L0 = 2'd0;
  localparam logic [LVL_W-1:0] LVL_L1 = 2'd1;
  localparam logic [LVL_W-1:0] LVL_L2 = 2'd2;
  localparam logic [LVL_W-1:0] LVL_L3 = 2'd3;

  // Request to the page-number reduction unit.
  typedef struct packed {
    logic                start;
    logic [PG_OFF_W-1:0] offset;
  } pgmod_req_t;

  // Table index for a walk level, taken from virtual page bits.
  function automatic logic [IDX_W-1:0] idx_of(input logic [VPN_W-1:0] vpn,
                                              input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    idx = '0;
    unique case (lvl)
      LVL_L0:  idx = vpn[35:27];
      LVL_L1:  idx = vpn[26:18];
      LVL_L2:  idx = vpn[17:9];
      LVL_L3:  idx = vpn[8:0];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

@@ sv/ptw_pgmod.sv @@
// Iterative reduction of a pool page offset modulo the pool size.
module ptw_pgmod #(
  parameter int unsigned POOL_PAGES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptw_pkg::pgmod_req_t             req_i,
  output logic                            done_o,
  output logic [$clog2(POOL_PAGES)-1:0]   page_o
);
  import ptw_pkg::*;

  localparam int unsigned PGW   = $clog2(POOL_PAGES);
  localparam int unsigned SUBW  = PG_OFF_W + $clog2(POOL_PAGES + 1);
  localparam int unsigned NSTEP = PG_OFF_W;
  localparam int unsigned SPC   = 4;
  localparam int unsigned NCYC  = (NSTEP + SPC - 1) / SPC;
  localparam int unsigned CNTW  = $clog2(NCYC + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic [PG_OFF_W-1:0] r_q, r_d;
  logic [PGW-1:0]      page_q, page_d;
  logic [SUBW-1:0]     rem;

  // Four compare-and-subtract steps of restoring reduction per cycle.
  always_comb begin
    int          k;
    logic [SUBW-1:0] sub;
    rem = SUBW'(r_q);
    sub = '0;
    k   = 0;
    for (int s = 0; s < SPC; s++) begin
      k = int'(NSTEP) - 1 - int'(cnt_q) * int'(SPC) - s;
      if (k >= 0) begin
        sub = SUBW'(POOL_PAGES) << k;
        if (rem >= sub) begin
          rem = rem - sub;
        end
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    page_d = page_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = req_i.offset;
    end else if (busy_q) begin
      r_d   = rem[PG_OFF_W-1:0];
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(NCYC - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        page_d = rem[PGW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    page_q <= page_d;
  end

  assign done_o = done_q;
  assign page_o = page_q;

  a_page_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (32'(page_q) < POOL_PAGES))
    else $error("reduced page number outside the pool");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("reduction restarted while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("done without a finished reduction");

endmodule

@@ sv/page_table_map_walker_unit.sv @@
// Four-level page table map walker with table memory and pool page allocator.
//
// Channel    Dir  Word fields (low bit first)
// s_axis     in   virtual_address[47:0], physical_address[95:48]
// m_axis     out  status[0], leaf_entry[48:1], leaf_table_page[54:49],
//                 new_tables[56:55], zero fill [63:57]
// cfg        in   pool_base (37 bits), written whenever cfg_we_i is high
//
// A request runs a counting walk and, when it maps, a writing walk; at each level
// a read of the table memory (read state, then evaluate state) plus, when the entry
// points on, a pass through the page-number reduction unit; each allocation and
// the leaf write is a state of its own. A request turned away for lack of pages
// ends after the counting walk. After reset a sweep clears the table memory, one
// entry a cycle, all (POOL_PAGES+1)*512 entries, with s_axis_tready low. A result
// waits in the output register while the next word is taken; the walk stalls at
// its end until that register is free.
module page_table_map_walker_unit #(
  parameter int unsigned POOL_PAGES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ptw_pkg::BASE_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ptw_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // virtual_address, physical_address
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ptw_pkg::M_TDATA_W-1:0]    m_axis_tdata    // status, leaf_entry,
                                                           // leaf_table_page, new_tables
);
  import ptw_pkg::*;

  localparam int unsigned RW    = $clog2(POOL_PAGES + 1);
  localparam int unsigned PGW   = $clog2(POOL_PAGES);
  localparam int unsigned DEPTH = (POOL_PAGES + 1) * TABLE_ENTRIES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned MEMW  = DESC_W + 1;
  localparam logic [RW-1:0] ROOT_PAGE = RW'(POOL_PAGES);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_RD    = 9'b000000100,
    ST_EVAL  = 9'b000001000,
    ST_MOD   = 9'b000010000,
    ST_CHECK = 9'b000100000,
    ST_ALLOC = 9'b001000000,
    ST_LEAF  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [BASE_W-1:0]  pool_base_q;
  logic [AW-1:0]      clr_q, clr_d;
  logic [RW-1:0]      nf_q, nf_d;
  logic [RW-1:0]      page_q, page_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic               pass_q, pass_d;
  logic [NEW_W-1:0]   need_q, need_d;
  logic [NEW_W-1:0]   made_q, made_d;
  logic [VPN_W-1:0]   vpn_q, vpn_d;
  logic [PPN_W-1:0]   ppn_q, ppn_d;

  logic                  res_status_q, res_status_d;
  logic [DESC_W-1:0]     res_leaf_q, res_leaf_d;
  logic [OUT_PAGE_W-1:0] res_page_q, res_page_d;
  logic [NEW_W-1:0]      res_new_q, res_new_d;

  logic                  m_valid_q, m_valid_d;
  logic                  out_status_q;
  logic [DESC_W-1:0]     out_leaf_q;
  logic [OUT_PAGE_W-1:0] out_page_q;
  logic [NEW_W-1:0]      out_new_q;
  logic                  out_load;

  // Table memory: bit 48 marks an entry written after its page was handed out.
  logic [MEMW-1:0] mem [DEPTH];
  logic [MEMW-1:0] rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [MEMW-1:0] mem_wdata;
  logic [AW-1:0]   mem_raddr;

  pgmod_req_t      mod_req;
  logic            mod_done;
  logic [PGW-1:0]  mod_page;

  logic [DESC_W-1:0]   ent;
  logic                ent_zero;
  logic [PG_OFF_W-1:0] alloc_addr;
  logic [DESC_W-1:0]   alloc_desc;
  logic [DESC_W-1:0]   leaf_desc;
  logic [RW-1:0]       free_pages;

  ptw_pgmod #(
    .POOL_PAGES(POOL_PAGES)
  ) u_pgmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .done_o (mod_done),
    .page_o (mod_page)
  );

  // An unmarked entry of a page already handed out reads as cleared.
  assign ent        = ((page_q < nf_q) && !rdata_q[DESC_W]) ? '0 : rdata_q[DESC_W-1:0];
  assign ent_zero   = (ent == '0);
  assign alloc_addr = pool_base_q[BASE_W-1:12] + PG_OFF_W'(nf_q);
  assign alloc_desc = {{(DESC_W - BASE_W){1'b0}}, alloc_addr, DESC_ATTR};
  assign leaf_desc  = {ppn_q, DESC_ATTR};
  assign free_pages = ROOT_PAGE - nf_q;
  assign mem_raddr  = {page_q, idx_of(vpn_q, lvl_q)};

  assign mod_req.start  = (state_q == ST_EVAL) && !ent_zero &&
                          !(!pass_q && (lvl_q == LVL_L2));
  assign mod_req.offset = ent[BASE_W-1:12] - pool_base_q[BASE_W-1:12];

  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mem_raddr;
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_ALLOC: begin
        mem_we    = 1'b1;
        mem_wdata = {(page_q <= nf_q), alloc_desc};
      end
      ST_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = {(page_q < nf_q), leaf_desc};
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    nf_d         = nf_q;
    page_d       = page_q;
    lvl_d        = lvl_q;
    pass_d       = pass_q;
    need_d       = need_q;
    made_d       = made_q;
    vpn_d        = vpn_q;
    ppn_d        = ppn_q;
    res_status_d = res_status_q;
    res_leaf_d   = res_leaf_q;
    res_page_d   = res_page_q;
    res_new_d    = res_new_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          vpn_d   = s_axis_tdata[VA_W-1:12];
          ppn_d   = s_axis_tdata[VA_W+PA_W-1:VA_W+12];
          pass_d  = 1'b0;
          lvl_d   = LVL_L0;
          page_d  = ROOT_PAGE;
          made_d  = '0;
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = ST_EVAL;
      ST_EVAL: begin
        if (!pass_q) begin
          if (ent_zero) begin
            need_d  = NEW_W'(3) - lvl_q;
            state_d = ST_CHECK;
          end else if (lvl_q == LVL_L2) begin
            need_d  = '0;
            state_d = ST_CHECK;
          end else begin
            state_d = ST_MOD;
          end
        end else if (ent_zero) begin
          state_d = ST_ALLOC;
        end else begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          page_d  = RW'(mod_page);
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = (pass_q && (lvl_q == LVL_L2)) ? ST_LEAF : ST_RD;
        end
      end
      ST_CHECK: begin
        if (RW'(need_q) > free_pages) begin
          res_status_d = 1'b1;
          res_leaf_d   = '0;
          res_page_d   = '0;
          res_new_d    = '0;
          state_d      = ST_DONE;
        end else begin
          pass_d  = 1'b1;
          lvl_d   = LVL_L0;
          page_d  = ROOT_PAGE;
          state_d = ST_RD;
        end
      end
      ST_ALLOC: begin
        page_d  = nf_q;
        nf_d    = nf_q + RW'(1);
        made_d  = made_q + NEW_W'(1);
        lvl_d   = lvl_q + LVL_W'(1);
        state_d = (lvl_q == LVL_L2) ? ST_LEAF : ST_RD;
      end
      ST_LEAF: begin
        res_status_d = 1'b0;
        res_leaf_d   = leaf_desc;
        res_page_d   = OUT_PAGE_W'(page_q);
        res_new_d    = made_q;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      nf_q        <= '0;
      pool_base_q <= BASE_W'(37'h0_0010_0000);
      m_valid_q   <= 1'b0;
      lvl_q       <= LVL_L0;
      pass_q      <= 1'b0;
      need_q      <= '0;
      made_q      <= '0;
      page_q      <= ROOT_PAGE;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      nf_q      <= nf_d;
      m_valid_q <= m_valid_d;
      lvl_q     <= lvl_d;
      pass_q    <= pass_d;
      need_q    <= need_d;
      made_q    <= made_d;
      page_q    <= page_d;
      if (cfg_we_i) begin
        pool_base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vpn_q        <= vpn_d;
    ppn_q        <= ppn_d;
    res_status_q <= res_status_d;
    res_leaf_q   <= res_leaf_d;
    res_page_q   <= res_page_d;
    res_new_q    <= res_new_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_leaf_q   <= res_leaf_q;
      out_page_q   <= res_page_q;
      out_new_q    <= res_new_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - 1 - DESC_W - OUT_PAGE_W - NEW_W){1'b0}},
                          out_new_q, out_page_q, out_leaf_q, out_status_q};

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nf_q) <= POOL_PAGES)
    else $error("allocator ran past the pool");

  a_alloc_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALLOC) |-> (32'(nf_q) < POOL_PAGES))
    else $error("allocation with no free page");

  a_made_le_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pass_q && (state_q != ST_IDLE) && (state_q != ST_CLEAR)) |-> (made_q <= need_q))
    else $error("writing walk allocated more tables than counted");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("table memory written while idle");

endmodule
